@@ design/itp_pkg.sv @@
package itp_pkg;

  localparam int NUM_IDS_DEF = 256;
  localparam int TIME_BITS   = 31;
  localparam int TOTAL_BITS  = 48;
  localparam int COUNT_BITS  = 32;
  localparam int PERIOD_BITS = 32;
  localparam int ID_BITS     = 8;

  localparam logic [ID_BITS-1:0]     RESERVED_ID  = 8'hFF;
  localparam logic [TIME_BITS-1:0]   STAMP_MAX    = {TIME_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX    = {TOTAL_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 32'h8000_0000;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_COUNT = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_UNKNOWN  = 2'd1;
  localparam logic [1:0] STS_REJECTED = 2'd2;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ID_BITS-1:0]   region_id;
    logic [TIME_BITS-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  entry_exists;
    logic                  is_running;
    logic [COUNT_BITS-1:0] entry_count;
    logic [TOTAL_BITS-1:0] total_time;
    logic [TIME_BITS-1:0]  min_time;
    logic [TIME_BITS-1:0]  max_time;
  } out_item_t;

  typedef struct packed {
    logic                  running;
    logic [TIME_BITS-1:0]  start_stamp;
    logic [COUNT_BITS-1:0] count;
    logic [TOTAL_BITS-1:0] total;
    logic [TIME_BITS-1:0]  min_time;
    logic [TIME_BITS-1:0]  max_time;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    running:     1'b0,
    start_stamp: '0,
    count:       '0,
    total:       '0,
    min_time:    STAMP_MAX,
    max_time:    '0
  };

  typedef struct packed {
    logic capture;
    logic eval;
    logic diff;
    logic update;
  } dp_ctrl_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

@@ design/itp_ctrl.sv @@
module itp_ctrl
  import itp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIFF = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ctrl.capture = 1'b0;
    ctrl.eval    = 1'b0;
    ctrl.diff    = 1'b0;
    ctrl.update  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_nxt    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ctrl.eval = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        ctrl.diff = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          ctrl.update = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/itp_datapath.sv @@
module itp_datapath
  import itp_pkg::*;
#(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  in_item_t               in_data,
  input  logic                   cfg_wr_en,
  input  logic [PERIOD_BITS-1:0] cfg_wr_data,
  input  dp_ctrl_t               ctrl,
  output dp_stat_t               stat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

  entry_t mem [NUM_IDS];

  logic [NUM_IDS-1:0]     valid_r;
  logic [PERIOD_BITS-1:0] period_r;
  in_item_t               item_r;
  entry_t                 rd_entry_r;
  logic                   rd_valid_r;
  entry_t                 cur_r;
  logic                   exists_r;
  logic                   wrap_r;
  logic [TIME_BITS+1:0]   sum_r;
  logic [TIME_BITS-1:0]   lin_r;
  logic [TIME_BITS-1:0]   diff_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [IDX_W-1:0]       in_idx;
  logic [IDX_W-1:0]       idx;
  logic                   rejected;
  logic [TIME_BITS+1:0]   diff_wide;
  logic [TOTAL_BITS:0]    total_sum;
  entry_t                 new_entry;
  logic                   wr_en;
  out_item_t              res;

  assign in_idx   = in_data.region_id[IDX_W-1:0];
  assign idx      = item_r.region_id[IDX_W-1:0];
  assign rejected = (item_r.region_id == RESERVED_ID) ||
                    (32'(item_r.region_id) >= NUM_IDS);

  assign stat.out_busy = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  // registered read of the entry store
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item_r     <= in_data;
      rd_entry_r <= mem[in_idx];
      rd_valid_r <= valid_r[in_idx];
    end
    if (wr_en) begin
      mem[idx] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[idx] <= 1'b1;
    end
  end

  // an entry never written reads as a fresh one
  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      cur_r    <= rd_valid_r ? rd_entry_r : ENTRY_RESET;
      exists_r <= rd_valid_r;
      wrap_r   <= (rd_valid_r ? rd_entry_r.start_stamp : '0) > item_r.timestamp;
      sum_r    <= (TIME_BITS+2)'(item_r.timestamp) + (TIME_BITS+2)'(period_r);
      lin_r    <= item_r.timestamp - (rd_valid_r ? rd_entry_r.start_stamp : '0);
    end
  end

  always_comb begin
    diff_wide = '0;
    if (wrap_r) begin
      if ((TIME_BITS+2)'(sum_r) >= (TIME_BITS+2)'(cur_r.start_stamp)) begin
        diff_wide = (TIME_BITS+2)'(sum_r) - (TIME_BITS+2)'(cur_r.start_stamp);
      end
    end else begin
      diff_wide = (TIME_BITS+2)'(lin_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff) begin
      if (diff_wide > (TIME_BITS+2)'(STAMP_MAX)) begin
        diff_r <= STAMP_MAX;
      end else begin
        diff_r <= diff_wide[TIME_BITS-1:0];
      end
    end
  end

  always_comb begin
    new_entry = cur_r;
    wr_en     = 1'b0;
    res       = '0;
    total_sum = (TOTAL_BITS+1)'(cur_r.total) + (TOTAL_BITS+1)'(diff_r);
    if (rejected) begin
      res.status = STS_REJECTED;
    end else if (!exists_r && (item_r.cmd inside {CMD_END, CMD_READ})) begin
      res.status = STS_UNKNOWN;
    end else begin
      case (item_r.cmd)
        CMD_START: begin
          new_entry.running     = 1'b1;
          new_entry.start_stamp = item_r.timestamp;
          if (cur_r.count != COUNT_MAX) begin
            new_entry.count = cur_r.count + 1'b1;
          end
          wr_en = ctrl.update;
        end
        CMD_COUNT: begin
          if (cur_r.count != COUNT_MAX) begin
            new_entry.count = cur_r.count + 1'b1;
          end
          wr_en = ctrl.update;
        end
        CMD_END: begin
          new_entry.running = 1'b0;
          if (diff_r > cur_r.max_time) begin
            new_entry.max_time = diff_r;
          end
          if (diff_r < cur_r.min_time) begin
            new_entry.min_time = diff_r;
          end
          if (total_sum > (TOTAL_BITS+1)'(TOTAL_MAX)) begin
            new_entry.total = TOTAL_MAX;
          end else begin
            new_entry.total = total_sum[TOTAL_BITS-1:0];
          end
          wr_en = ctrl.update;
        end
        default: begin
        end
      endcase
      res.status       = STS_OK;
      res.entry_exists = 1'b1;
      res.is_running   = new_entry.running;
      res.entry_count  = new_entry.count;
      res.total_time   = new_entry.total;
      res.min_time     = new_entry.min_time;
      res.max_time     = new_entry.max_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.update) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      out_r <= res;
    end
  end

endmodule

@@ design/interval_timing_profiler_top.sv @@
// Each item passes the read, evaluate, interval and update steps of the
// controller around the single-port entry store, and no new item is taken
// before its update registers the result; update waits on a stalled output.
// Reset (synchronous, rst_n low): all entries read as empty, the timer period
// returns to 2^31, no result is pending; the store itself needs no clearing.
module interval_timing_profiler_top
  import itp_pkg::*;
#(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_wr_en,
  input  logic [PERIOD_BITS-1:0] cfg_wr_data
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  itp_datapath #(
    .NUM_IDS (NUM_IDS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
